// File: hw/rtl/udiv256_pkg.sv
// Shared types and constants for the 256-bit unsigned divider.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package udiv256_pkg;

  localparam int WordWidth = 64;
  localparam int NumWords = 4;
  localparam int DivWidth = WordWidth * NumWords;
  localparam int StepCountWidth = $clog2(DivWidth);

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [DivWidth-1:0] wide_t;
  typedef logic [StepCountWidth-1:0] step_count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic divisor_zero;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/udiv256_ctrl.sv
// Controller state machine for the 256-bit divider: sequences load, steps and done.
// Depends on udiv256_pkg for the command and status types.
`default_nettype none

module udiv256_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  udiv256_pkg::dp_status_t status,
  output udiv256_pkg::dp_cmd_t    cmd,
  output logic                    busy,
  output logic                    done
);
  import udiv256_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t      state;
  step_count_t count;
  logic        accept;
  logic        running;

  assign accept = start && !busy;
  assign running = (state == ST_RUN);

  always_comb begin
    cmd.load = accept;
    cmd.step = running && !status.divisor_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE, ST_DONE: begin
          done <= 1'b0;
          if (accept) begin
            state <= ST_RUN;
            count <= '1;
            busy  <= 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (status.divisor_zero || count == '0) begin
            state <= ST_DONE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            count <= count - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/udiv256_datapath.sv
// Datapath for the 256-bit divider: restoring shift-subtract, one quotient bit per step.
// Depends on udiv256_pkg for widths and the command and status types.
`default_nettype none

module udiv256_datapath (
  input  wire                     clk,
  input  udiv256_pkg::dp_cmd_t    cmd,
  input  udiv256_pkg::wide_t      dividend,
  input  udiv256_pkg::wide_t      divisor,
  output udiv256_pkg::dp_status_t status,
  output udiv256_pkg::wide_t      quotient,
  output udiv256_pkg::wide_t      remainder,
  output logic                    divide_by_zero
);
  import udiv256_pkg::*;

  // The dividend shifts out at the top of num_quo while quotient bits enter at the bottom.
  wide_t                num_quo;
  wide_t                rem;
  wide_t                den;
  logic                 den_zero;
  logic [DivWidth:0]    rem_shift;
  logic [DivWidth+1:0]  diff;
  logic                 fits;

  assign rem_shift = {rem, num_quo[DivWidth-1]};
  assign diff = {1'b0, rem_shift} - {2'b00, den};
  assign fits = !diff[DivWidth+1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_quo  <= dividend;
      rem      <= '0;
      den      <= divisor;
      den_zero <= (divisor == '0);
    end else if (cmd.step) begin
      num_quo <= {num_quo[DivWidth-2:0], fits};
      rem     <= fits ? diff[DivWidth-1:0] : rem_shift[DivWidth-1:0];
    end
  end

  assign status.divisor_zero = den_zero;
  assign quotient = den_zero ? '0 : num_quo;
  assign remainder = den_zero ? num_quo : rem;
  assign divide_by_zero = den_zero;

endmodule

`default_nettype wire

// File: hw/rtl/unsigned_256bit_divider_unit.sv
// Top level of the 256-bit unsigned divider: controller plus datapath.
// Depends on udiv256_pkg, udiv256_ctrl and udiv256_datapath.
// done pulses when all quotient bits are formed; a zero divisor ends ST_RUN without any step.
// Throughput: one quotient bit per cycle from a 258-bit subtractor; no new start is taken while busy.
// A new start is taken in the cycle that done is high. Results cannot be stalled.
// Reset is synchronous and returns the controller to idle; data registers are not reset.
`default_nettype none

module unsigned_256bit_divider_unit (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  output logic                     done,
  input  wire  [63:0]              dividend_word0,
  input  wire  [63:0]              dividend_word1,
  input  wire  [63:0]              dividend_word2,
  input  wire  [63:0]              dividend_word3,
  input  wire  [63:0]              divisor_word0,
  input  wire  [63:0]              divisor_word1,
  input  wire  [63:0]              divisor_word2,
  input  wire  [63:0]              divisor_word3,
  output logic [63:0]              quotient_word0,
  output logic [63:0]              quotient_word1,
  output logic [63:0]              quotient_word2,
  output logic [63:0]              quotient_word3,
  output logic [63:0]              remainder_word0,
  output logic [63:0]              remainder_word1,
  output logic [63:0]              remainder_word2,
  output logic [63:0]              remainder_word3,
  output logic                     divide_by_zero
);
  import udiv256_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  wide_t      dividend;
  wide_t      divisor;
  wide_t      quotient;
  wide_t      remainder;

  assign dividend = {dividend_word3, dividend_word2, dividend_word1, dividend_word0};
  assign divisor = {divisor_word3, divisor_word2, divisor_word1, divisor_word0};

  udiv256_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  udiv256_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .dividend       (dividend),
    .divisor        (divisor),
    .status         (status),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  assign quotient_word0 = quotient[WordWidth-1:0];
  assign quotient_word1 = quotient[2*WordWidth-1:WordWidth];
  assign quotient_word2 = quotient[3*WordWidth-1:2*WordWidth];
  assign quotient_word3 = quotient[4*WordWidth-1:3*WordWidth];
  assign remainder_word0 = remainder[WordWidth-1:0];
  assign remainder_word1 = remainder[2*WordWidth-1:WordWidth];
  assign remainder_word2 = remainder[3*WordWidth-1:2*WordWidth];
  assign remainder_word3 = remainder[4*WordWidth-1:3*WordWidth];

endmodule

`default_nettype wire

// File: hw/rtl/udiv256_checker.sv
// Port-level checks for the 256-bit divider and the bind that attaches them.
// Depends only on the ports of unsigned_256bit_divider_unit.
`default_nettype none

module udiv256_port_props (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire [63:0] quotient_word0,
  input wire [63:0] quotient_word1,
  input wire [63:0] quotient_word2,
  input wire [63:0] quotient_word3,
  input wire        divide_by_zero
);

  // A transfer on start always makes the unit busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("unit not busy after a start transfer");

  // A result is never presented while the unit reports busy.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

  // Each result is shown for exactly one cycle.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // A zero divisor yields a zero quotient.
  assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (quotient_word0 == 64'd0 && quotient_word1 == 64'd0 &&
                                  quotient_word2 == 64'd0 && quotient_word3 == 64'd0))
    else $error("nonzero quotient on divide by zero");

endmodule

bind unsigned_256bit_divider_unit udiv256_port_props u_port_props (.*);

`default_nettype wire
